// ===== src/oef_pkg.sv =====
// Package for the one euro smoothing filter: constants, state type and divider select type.
package oef_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CFG_WIDTH      = 24;
   localparam int CFG_IDX_WIDTH  = 2;
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_BASE_CUTOFF  = 2'd0;
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPEED_GAIN   = 2'd1;
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_SLOPE_CUTOFF = 2'd2;
   localparam logic [CFG_WIDTH-1:0] BASE_CUTOFF_RESET  = 24'd65536;
   localparam logic [CFG_WIDTH-1:0] SPEED_GAIN_RESET   = 24'd0;
   localparam logic [CFG_WIDTH-1:0] SLOPE_CUTOFF_RESET = 24'd65536;
   localparam logic [35:0] TWO_PI_Q30 = 36'd6746518852;
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_INIT   = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DSTART,
      ST_DITER,
      ST_DROUND,
      ST_SLOPE,
      ST_AD_M1,
      ST_AD_M2,
      ST_AD_DIV,
      ST_DH_MUL,
      ST_DH_ADD,
      ST_CUT_MUL,
      ST_CUT_ADD,
      ST_AV_M1,
      ST_AV_M2,
      ST_AV_DIV,
      ST_EV_MUL,
      ST_EV_ADD,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_SLOPE,
      DIV_ALPHA_D,
      DIV_ALPHA_V
   } div_sel_type;
endpackage

// ===== src/one_euro_smoothing_filter.sv =====
// One euro smoothing filter top level: sequencer around a shared multiplier and divider.
//   channel | direction | signals
//   req     | in        | req_valid, req_stall, command, time, value, slope
//   rsp     | out       | rsp_valid, rsp_stall, filtered_value, bad_interval
//   csr     | in        | csr_write, csr_index, csr_data
// An init item or a bad interval goes from idle straight to the done state. A filter
// item runs three long divisions through one restoring divider, one quotient bit a
// cycle; products go through one multiplier.
// Reset loads the register defaults and clears state. The next request is taken
// once the sequencer is idle and the result register is empty or being taken.
module one_euro_smoothing_filter import oef_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [DATA_WIDTH-1:0]        req_sample_time,
   input  logic signed [DATA_WIDTH-1:0] req_sample_value,
   input  logic signed [DATA_WIDTH-1:0] req_initial_slope,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_filtered_value,
   output logic                         rsp_bad_interval,
   input  logic                         csr_write,
   input  logic [CFG_IDX_WIDTH-1:0]     csr_index,
   input  logic [CFG_WIDTH-1:0]         csr_data
);
   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int XW = W + 2;
   localparam int PW = 2 * XW;
   localparam int NW = W + F + 2;
   localparam int CW = $clog2(NW + 1);
   localparam logic [XW-1:0] WMAX = XW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [XW-1:0] ONE_Q = XW'(64'd1 << F);
   localparam logic [XW-1:0] TWO_PI_Q =
      XW'((TWO_PI_Q30 + (36'd1 << (29 - F))) >> (30 - F));
   localparam logic signed [XW:0] SMAX = (XW+1)'(WMAX);
   localparam logic signed [XW:0] SMIN = ~SMAX;

   state_type state_ff, state_in;
   div_sel_type dsel_ff, dsel_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [CFG_WIDTH-1:0] base_cut_ff, gain_ff, slope_cut_ff;
   logic signed [W-1:0] est_ff, est_in, slp_ff, slp_in;
   logic [W-1:0] tim_ff, tim_in;

   logic [W-1:0] t_ff, t_in, te_ff, te_in;
   logic signed [W-1:0] x_ff, x_in;
   logic [XW-1:0] acc_ff, acc_in;
   logic acc_neg_ff, acc_neg_in;
   logic [XW-1:0] r_ff, r_in;
   logic [NW-1:0] num_ff, num_in, q_ff, q_in;
   logic [XW-1:0] den_ff, den_in;
   logic [XW:0] rem_ff, rem_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_bad_ff, rsp_bad_in;
   logic signed [W-1:0] rsp_val_ff, rsp_val_in;

   logic [XW-1:0] ma, mb;
   logic [PW-1:0] prod, prod_r;
   logic [XW-1:0] mres;
   logic signed [XW:0] sum_s, clamped;
   logic [XW:0] trial;
   logic req_take;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      prod   = ma * mb;
      prod_r = prod + PW'(1 << (F - 1));
      if ((prod_r >> F) > PW'(WMAX)) mres = WMAX;
      else mres = XW'(prod_r >> F);
   end

   function automatic logic [XW-1:0] mag(input logic signed [XW:0] v);
      logic [XW:0] m;
      m = v[XW] ? -v : v;
      return m[XW-1:0];
   endfunction

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         ST_AD_M1:   begin ma = TWO_PI_Q; mb = XW'(slope_cut_ff); end
         ST_AV_M1:   begin ma = TWO_PI_Q; mb = acc_ff; end
         ST_AD_M2,
         ST_AV_M2:   begin ma = r_ff; mb = XW'(te_ff); end
         ST_DH_ADD,
         ST_EV_ADD:  begin ma = r_ff; mb = acc_ff; end
         ST_CUT_ADD: begin ma = XW'(gain_ff); mb = acc_ff; end
         default:    ;
      endcase
   end

   always_comb begin
      trial = {rem_ff[XW-1:0], num_ff[NW-1]} - {1'b0, den_ff};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) begin
            if (req_command == CMD_INIT || req_sample_time <= tim_ff) state_in = ST_DONE;
            else state_in = ST_DSTART;
         end
         ST_DSTART:  state_in = ST_DITER;
         ST_DITER:   if (cnt_ff == CW'(1)) state_in = ST_DROUND;
         ST_DROUND: begin
            unique case (dsel_ff)
               DIV_SLOPE:   state_in = ST_SLOPE;
               DIV_ALPHA_D: state_in = ST_DH_MUL;
               default:     state_in = ST_EV_MUL;
            endcase
         end
         ST_SLOPE:   state_in = ST_AD_M1;
         ST_AD_M1:   state_in = ST_AD_M2;
         ST_AD_M2:   state_in = ST_AD_DIV;
         ST_AD_DIV:  state_in = ST_DITER;
         ST_DH_MUL:  state_in = ST_DH_ADD;
         ST_DH_ADD:  state_in = ST_CUT_MUL;
         ST_CUT_MUL: state_in = ST_CUT_ADD;
         ST_CUT_ADD: state_in = ST_AV_M1;
         ST_AV_M1:   state_in = ST_AV_M2;
         ST_AV_M2:   state_in = ST_AV_DIV;
         ST_AV_DIV:  state_in = ST_DITER;
         ST_EV_MUL:  state_in = ST_EV_ADD;
         ST_EV_ADD:  state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dsel_in = dsel_ff; cnt_in = cnt_ff;
      est_in = est_ff; slp_in = slp_ff; tim_in = tim_ff;
      t_in = t_ff; te_in = te_ff; x_in = x_ff;
      acc_in = acc_ff; acc_neg_in = acc_neg_ff; r_in = r_ff;
      num_in = num_ff; q_in = q_ff; den_in = den_ff; rem_in = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_val_in = rsp_val_ff; rsp_bad_in = rsp_bad_ff;
      sum_s = '0; clamped = '0;
      unique case (state_ff)
         ST_IDLE: if (req_take) begin
            t_in = req_sample_time;
            x_in = req_sample_value;
            te_in = req_sample_time - tim_ff;
            if (req_command == CMD_INIT) begin
               tim_in = req_sample_time;
               est_in = req_sample_value;
               slp_in = req_initial_slope;
               rsp_bad_in = 1'b0;
            end else begin
               rsp_bad_in = req_sample_time <= tim_ff;
               sum_s = (XW+1)'(req_sample_value) - (XW+1)'(est_ff);
               acc_neg_in = sum_s[XW];
               num_in = NW'(mag(sum_s)) << F;
               den_in = XW'(req_sample_time - tim_ff);
               dsel_in = DIV_SLOPE;
            end
         end
         ST_DSTART, ST_AD_DIV, ST_AV_DIV: begin
            if (state_ff != ST_DSTART) begin
               num_in = NW'(r_ff) << F;
               den_in = r_ff + ONE_Q;
               dsel_in = (state_ff == ST_AD_DIV) ? DIV_ALPHA_D : DIV_ALPHA_V;
            end
            rem_in = '0; q_in = '0; cnt_in = CW'(NW);
         end
         ST_DITER: begin
            if (!trial[XW]) begin
               rem_in = trial;
               q_in = {q_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[XW-1:0], num_ff[NW-1]};
               q_in = {q_ff[NW-2:0], 1'b0};
            end
            num_in = {num_ff[NW-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
         end
         ST_DROUND: begin
            q_in = q_ff + NW'(({rem_ff, 1'b0}) >= {2'b0, den_ff});
            if (dsel_ff == DIV_SLOPE) begin
               if (q_in > NW'(WMAX)) q_in = NW'(WMAX);
            end else if (q_in > NW'(ONE_Q)) q_in = NW'(ONE_Q);
            r_in = XW'(q_in);
         end
         ST_SLOPE: begin
            acc_in = acc_neg_ff ? -XW'(r_ff) : r_ff;
         end
         ST_AD_M1, ST_AD_M2, ST_AV_M1, ST_AV_M2: r_in = mres;
         ST_DH_MUL: begin
            sum_s = (XW+1)'(signed'(acc_ff)) - (XW+1)'(slp_ff);
            acc_neg_in = sum_s[XW];
            acc_in = mag(sum_s);
         end
         ST_EV_MUL: begin
            sum_s = (XW+1)'(x_ff) - (XW+1)'(est_ff);
            acc_neg_in = sum_s[XW];
            acc_in = mag(sum_s);
         end
         ST_DH_ADD, ST_EV_ADD: begin
            sum_s = (XW+1)'(state_ff == ST_DH_ADD ? slp_ff : est_ff) +
                    (acc_neg_ff ? -(XW+1)'(mres) : (XW+1)'(mres));
            clamped = sum_s;
            if (sum_s > SMAX) clamped = SMAX;
            if (sum_s < SMIN) clamped = SMIN;
            if (state_ff == ST_DH_ADD) begin
               slp_in = W'(clamped);
               acc_in = mag(clamped);
            end else begin
               est_in = W'(clamped);
               tim_in = t_ff;
            end
         end
         ST_CUT_ADD: begin
            sum_s = (XW+1)'(base_cut_ff) + (XW+1)'(mres);
            acc_in = (sum_s > SMAX) ? WMAX : XW'(sum_s);
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_val_in = est_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dsel_ff <= DIV_SLOPE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         est_ff <= '0; slp_ff <= '0; tim_ff <= '0;
         base_cut_ff <= BASE_CUTOFF_RESET;
         gain_ff <= SPEED_GAIN_RESET;
         slope_cut_ff <= SLOPE_CUTOFF_RESET;
      end else begin
         state_ff <= state_in;
         dsel_ff <= dsel_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff <= est_in; slp_ff <= slp_in; tim_ff <= tim_in;
         if (csr_write) begin
            unique case (csr_index)
               CFG_BASE_CUTOFF:  base_cut_ff <= csr_data;
               CFG_SPEED_GAIN:   gain_ff <= csr_data;
               CFG_SLOPE_CUTOFF: slope_cut_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; te_ff <= te_in; x_ff <= x_in;
      acc_ff <= acc_in; acc_neg_ff <= acc_neg_in; r_ff <= r_in;
      num_ff <= num_in; q_ff <= q_in; den_ff <= den_in; rem_ff <= rem_in;
      rsp_val_ff <= rsp_val_in; rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_value = rsp_val_ff;
   assign rsp_bad_interval = rsp_bad_ff;

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("request taken while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("result lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_filtered_value))
      else $error("stalled result changed");
endmodule
